/* design/modexp_pkg.sv */
// Package for the modular exponentiation block: word types, controller codes and widths.
package modexp_pkg;

  // Operand width used by the arithmetic; input fields are truncated to it
  localparam int WIDTH   = 32;
  localparam int FIELD_W = 32;
  localparam int CNT_W   = $clog2(WIDTH);

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] power_result;
    logic               zero_modulus_error;
  } out_word_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_BASE,
    DP_MUL_SQ,
    DP_MUL_B,
    DP_RED,
    DP_WB_BASE,
    DP_WB_ACC,
    DP_NEXT_BIT,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_msb;
    logic red_last;
    logic bit_last;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_BASE,
    S_SQ,
    S_MB,
    S_RED,
    S_WB,
    S_NEXT,
    S_EMIT
  } ctrl_state_t;

  // Which multiplication the reduction belongs to
  typedef enum logic [1:0] {
    PH_BASE,
    PH_SQ,
    PH_MB
  } phase_t;

endpackage

/* design/modexp_datapath.sv */
// Datapath of the modular exponentiation block: operand registers, multiplier, serial reducer.
module modexp_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  modexp_pkg::in_word_t in_word,
  input  modexp_pkg::dp_cmd_t  cmd,
  output modexp_pkg::dp_sts_t  sts,
  output modexp_pkg::out_word_t out_word
);
  import modexp_pkg::*;

  logic [WIDTH-1:0]   mod_r, base_r, acc_r, exp_r, rem_r;
  logic [2*WIDTH-1:0] prod_r;
  logic [CNT_W-1:0]   red_cnt_r, bit_cnt_r;
  logic               err_r;
  out_word_t          out_r;

  logic [2*WIDTH-1:0] mul_res;
  logic [WIDTH-1:0]   mul_b;
  logic [WIDTH:0]     step1, step1_red, step2, step2_red;
  logic [WIDTH-1:0]   rem_nxt;

  // Multiplier: acc times acc or acc times reduced base
  assign mul_b   = (cmd.op == DP_MUL_B) ? base_r : acc_r;
  assign mul_res = (2*WIDTH)'(acc_r) * (2*WIDTH)'(mul_b);

  // Restoring reduction, two product bits per cycle, MSB first
  always_comb begin
    step1     = {rem_r, prod_r[2*WIDTH-1]};
    step1_red = (step1 >= {1'b0, mod_r}) ? (step1 - {1'b0, mod_r}) : step1;
    step2     = {step1_red[WIDTH-1:0], prod_r[2*WIDTH-2]};
    step2_red = (step2 >= {1'b0, mod_r}) ? (step2 - {1'b0, mod_r}) : step2;
    rem_nxt   = step2_red[WIDTH-1:0];
  end

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_cnt_r <= '0;
      bit_cnt_r <= '0;
    end else begin
      case (cmd.op)
        DP_LOAD:     bit_cnt_r <= '0;
        DP_MUL_BASE,
        DP_MUL_SQ,
        DP_MUL_B:    red_cnt_r <= '0;
        DP_RED:      red_cnt_r <= red_cnt_r + 1'b1;
        DP_NEXT_BIT: bit_cnt_r <= bit_cnt_r + 1'b1;
        default: ;
      endcase
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        base_r <= in_word.base[WIDTH-1:0];
        exp_r  <= in_word.exponent[WIDTH-1:0];
        mod_r  <= in_word.modulus[WIDTH-1:0];
        acc_r  <= WIDTH'(1);
        err_r  <= (in_word.modulus[WIDTH-1:0] == '0);
      end
      DP_MUL_BASE: begin
        prod_r <= (2*WIDTH)'(base_r);
        rem_r  <= '0;
      end
      DP_MUL_SQ, DP_MUL_B: begin
        prod_r <= mul_res;
        rem_r  <= '0;
      end
      DP_RED: begin
        prod_r <= {prod_r[2*WIDTH-3:0], 2'b00};
        rem_r  <= rem_nxt;
      end
      DP_WB_BASE:  base_r <= rem_r;
      DP_WB_ACC:   acc_r  <= rem_r;
      DP_NEXT_BIT: exp_r  <= {exp_r[WIDTH-2:0], 1'b0};
      DP_EMIT: begin
        out_r.power_result       <= err_r ? '0 : FIELD_W'(acc_r);
        out_r.zero_modulus_error <= err_r;
      end
      default: ;
    endcase
  end

  assign sts.mod_zero = (mod_r == '0);
  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_msb  = exp_r[WIDTH-1];
  assign sts.red_last = (red_cnt_r == CNT_W'(WIDTH-1));
  assign sts.bit_last = (bit_cnt_r == CNT_W'(WIDTH-1));
  assign out_word     = out_r;

endmodule

/* design/modexp_ctrl.sv */
// Controller of the modular exponentiation block: sequences the square-and-multiply steps.
module modexp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  modexp_pkg::dp_sts_t sts,
  output modexp_pkg::dp_cmd_t cmd
);
  import modexp_pkg::*;

  ctrl_state_t state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_BASE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = DP_NOP;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mod_zero || sts.exp_zero) state_nxt = S_EMIT;
        else                              state_nxt = S_BASE;
      end
      S_BASE: begin
        cmd.op    = DP_MUL_BASE;
        phase_nxt = PH_BASE;
        state_nxt = S_RED;
      end
      S_SQ: begin
        cmd.op    = DP_MUL_SQ;
        phase_nxt = PH_SQ;
        state_nxt = S_RED;
      end
      S_MB: begin
        cmd.op    = DP_MUL_B;
        phase_nxt = PH_MB;
        state_nxt = S_RED;
      end
      S_RED: begin
        cmd.op = DP_RED;
        if (sts.red_last) state_nxt = S_WB;
      end
      S_WB: begin
        case (phase_r)
          PH_BASE: begin
            cmd.op    = DP_WB_BASE;
            state_nxt = S_SQ;
          end
          PH_SQ: begin
            cmd.op    = DP_WB_ACC;
            state_nxt = sts.exp_msb ? S_MB : S_NEXT;
          end
          default: begin
            cmd.op    = DP_WB_ACC;
            state_nxt = S_NEXT;
          end
        endcase
      end
      S_NEXT: begin
        if (sts.bit_last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = DP_NEXT_BIT;
          state_nxt = S_SQ;
        end
      end
      S_EMIT: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* design/modular_exponentiation_top.sv */
// Top level of the modular exponentiation block: controller plus datapath.
// Computes base^exponent mod modulus by left-to-right square-and-multiply over all
// 32 exponent bits. An item with a zero modulus or zero exponent goes only through
// load, check and emit. Any other item also runs a base reduction, then for each of
// the 32 exponent bits a square plus a multiply when the bit is set, and then emit.
// Every product goes through the serial reducer, which retires two product bits per
// cycle, works through each 64-bit product and is shared by every multiplication.
// A new word is accepted once the previous item is finished, even while its result
// still waits in the output register.
module modular_exponentiation_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  modexp_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output modexp_pkg::out_word_t out_word
);
  import modexp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  modexp_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

/* design/modexp_checker.sv */
// Port-level assertion checker for the modular exponentiation block, with its bind.
module modexp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input modexp_pkg::in_word_t  in_word,
  input logic                  out_valid,
  input logic                  out_ready,
  input modexp_pkg::out_word_t out_word
);
  import modexp_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Error results carry a zero power
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.zero_modulus_error |-> out_word.power_result == '0)
    else $error("error result with nonzero power");

  // Block is busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a word");

  // A new result never appears while input side is open
  a_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while block was idle");

endmodule

bind modular_exponentiation_top modexp_checker u_modexp_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for the modular exponentiation block: directed table, then random words.
`timescale 1ns / 100ps

module tb_top;
  import modexp_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int IDLE_LIMIT = 20000;  // watchdog limit, above the slowest item (all exponent bits set)
  localparam int TAIL_WAIT  = 2300;   // wait after the last result, longer than the slowest item
  localparam int RAND_WORDS = 64;     // per idling phase
  localparam int DIR_ROWS   = 18;

  // One directed row: input word, and a typed-in result where it is obvious
  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // Side info that travels with the word on the input channel
  logic      cur_typed;
  out_word_t cur_want;

  out_word_t pending_powers[$];
  out_word_t head_power;
  dir_row_t  dir_rows [0:DIR_ROWS-1];

  int fail_count     = 0;
  int words_sent     = 0;
  int words_taken    = 0;
  int idle_cycles    = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  modular_exponentiation_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #(CLK_HALF) clk = ~clk;

  // Left-to-right square-and-multiply over all WIDTH exponent bits
  function automatic out_word_t modexp_predict(in_word_t w);
    logic [63:0] keep;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] acc;
    out_word_t   r;
    keep = (64'd1 << WIDTH) - 64'd1;
    b = {{(64-FIELD_W){1'b0}}, w.base} & keep;
    e = {{(64-FIELD_W){1'b0}}, w.exponent} & keep;
    m = {{(64-FIELD_W){1'b0}}, w.modulus} & keep;
    r = '0;
    if (m == 64'd0) begin
      r.zero_modulus_error = 1'b1;
    end else if (e == 64'd0) begin
      r.power_result = FIELD_W'(1);
    end else begin
      b   = b % m;
      acc = 64'd1 % m;
      for (int i = WIDTH - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (e[i]) begin
          acc = (acc * b) % m;
        end
      end
      r.power_result = acc[FIELD_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    fail_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(in_word_t w, logic typed, out_word_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_word   <= w;
    cur_typed <= typed;
    cur_want  <= want;
    words_sent++;
    @(negedge clk);
    while (words_taken != words_sent) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_powers.size() != 0) @(negedge clk);
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Scoreboard and watchdog, all sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_powers.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: %h", out_word));
        end else begin
          head_power = pending_powers.pop_front();
          if (out_word.power_result !== head_power.power_result) begin
            report_mismatch($sformatf("power_result %h, want %h",
                                      out_word.power_result, head_power.power_result));
          end
          if (out_word.zero_modulus_error !== head_power.zero_modulus_error) begin
            report_mismatch($sformatf("zero_modulus_error %b, want %b",
                                      out_word.zero_modulus_error,
                                      head_power.zero_modulus_error));
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_powers.insert(pending_powers.size(),
                              cur_typed ? cur_want : modexp_predict(in_word));
        words_taken <= words_taken + 1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    in_word_t w;
    int       pick;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cur_typed = 1'b0;
    cur_want  = '0;

    // base, exponent, modulus -> typed flag, power_result, error flag
    dir_rows = '{
      // zero modulus, with and without a zero exponent
      '{'{32'd5,          32'd7,          32'd0},          1'b1, '{32'd0, 1'b1}},
      '{'{32'hFFFFFFFF,   32'd0,          32'd0},          1'b1, '{32'd0, 1'b1}},
      // zero exponent gives one, modulus one included; then a zero base
      '{'{32'hFFFFFFFF,   32'd0,          32'd1},          1'b1, '{32'd1, 1'b0}},
      '{'{32'd0,          32'd0,          32'hFFFFFFFF},   1'b1, '{32'd1, 1'b0}},
      '{'{32'd0,          32'd1,          32'hFFFFFFFF},   1'b1, '{32'd0, 1'b0}},
      // base equal to modulus reduces to zero, then small typed-in cases
      '{'{32'hFFFFFFFF,   32'hFFFFFFFF,   32'hFFFFFFFF},   1'b1, '{32'd0, 1'b0}},
      '{'{32'd12345,      32'd5,          32'd1},          1'b1, '{32'd0, 1'b0}},
      '{'{32'd2,          32'd10,         32'd1000},       1'b1, '{32'd24, 1'b0}},
      '{'{32'd10,         32'd3,          32'd1001},       1'b1, '{32'd1000, 1'b0}},
      '{'{32'd5,          32'd1,          32'd3},          1'b1, '{32'd2, 1'b0}},
      '{'{32'd1,          32'hFFFFFFFF,   32'd2},          1'b1, '{32'd1, 1'b0}},
      '{'{32'hFFFFFFFF,   32'd1,          32'd2},          1'b1, '{32'd1, 1'b0}},
      // full-width operands, checked against the predictor
      '{'{32'hFFFFFFFE,   32'hFFFFFFFF,   32'hFFFFFFFF},   1'b0, '{32'd0, 1'b0}},
      '{'{32'hFFFFFFFF,   32'd2,          32'hFFFFFFFE},   1'b0, '{32'd0, 1'b0}},
      '{'{32'd3,          32'h80000000,   32'hFFFFFFFB},   1'b0, '{32'd0, 1'b0}},
      '{'{32'd7,          32'hFFFFFFFF,   32'h80000000},   1'b0, '{32'd0, 1'b0}},
      '{'{32'h12345678,   32'h0000FFFF,   32'h7FFFFFFF},   1'b0, '{32'd0, 1'b0}},
      '{'{32'hDEADBEEF,   32'h55555555,   32'hAAAAAAAA},   1'b0, '{32'd0, 1'b0}}
    };

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, no idling
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);
    end
    wait_drained();

    // Random words over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 67; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 67; end
        default: begin send_gap_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < RAND_WORDS; n++) begin
        pick       = $urandom_range(0, 99);
        w.base     = $urandom;
        w.exponent = $urandom;
        w.modulus  = $urandom;
        if (pick < 5) begin
          w.modulus = '0;
        end else if (pick < 10) begin
          w.exponent = '0;
        end else if (pick < 14) begin
          w.modulus = FIELD_W'(1);
        end else if (pick < 30) begin
          // small modulus so the base reduction does real work
          w.modulus = $urandom_range(2, 1000);
        end else if (pick < 40) begin
          w.exponent = $urandom_range(1, 15);
        end else if (pick < 48) begin
          w.modulus[FIELD_W-1] = 1'b1;
        end else if (pick < 54) begin
          w.base = w.modulus;
        end
        send_word(w, 1'b0, '0);
        // occasional full drain before the next word
        if ($urandom_range(0, 19) == 0) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    // Drain and give any stray result time to show up
    in_valid <= 1'b0;
    while (pending_powers.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/modexp_pkg.sv
design/modexp_datapath.sv
design/modexp_ctrl.sv
design/modular_exponentiation_top.sv
design/modexp_checker.sv
verif/tb_top.sv
